>>> design/mlsrjf_pkg.sv
// ----------------------------------------------------------------------------
// mlsrjf_pkg
// Shared types, constants and helpers for the multilevel SRJF scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package mlsrjf_pkg;

  // Default sizing
  localparam int MLSRJF_MAX_TASKS = 32;
  localparam int MLSRJF_TIME_BITS = 16;
  localparam int MLSRJF_SUM_BITS  = 32;
  localparam int MLSRJF_ID_BITS   = 8;
  localparam int MLSRJF_LVL_BITS  = 2;

  // Stored level codes
  localparam logic [MLSRJF_LVL_BITS-1:0] LEVEL_HIGH   = 2'd1;
  localparam logic [MLSRJF_LVL_BITS-1:0] LEVEL_MEDIUM = 2'd2;

  // Served rank codes
  localparam logic [1:0] RANK_HIGH   = 2'd0;
  localparam logic [1:0] RANK_MEDIUM = 2'd1;
  localparam logic [1:0] RANK_LOW    = 2'd2;

  // Input kind codes
  localparam logic KIND_ADD  = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } sched_state_t;

  // Map a stored level to its served rank
  function automatic logic [1:0] level_rank(input logic [MLSRJF_LVL_BITS-1:0] lv);
    logic [1:0] rank;
    if (lv == LEVEL_HIGH) begin
      rank = RANK_HIGH;
    end else if (lv == LEVEL_MEDIUM) begin
      rank = RANK_MEDIUM;
    end else begin
      rank = RANK_LOW;
    end
    return rank;
  endfunction

endpackage

`default_nettype wire

>>> design/mlsrjf_ram.sv
// ----------------------------------------------------------------------------
// mlsrjf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mlsrjf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> design/multilevel_srjf_scheduler_top.sv
// ----------------------------------------------------------------------------
// multilevel_srjf_scheduler_top: multilevel preemptive SRJF task scheduler.
// Add transfer: stored in the cycle it is taken, ready again the next cycle.
// Tick transfer: the table is read entry by entry through one compare unit,
// then a drain step and an update; an empty table goes straight to the update.
// Input ready again after the update; a held result stalls the update.
// Reset (rst_n low, synchronous) clears counts, time, totals and handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module multilevel_srjf_scheduler_top
  import mlsrjf_pkg::*;
#(
  parameter int MAX_TASKS = MLSRJF_MAX_TASKS,
  parameter int TIME_BITS = MLSRJF_TIME_BITS,
  localparam int IN_FW    = MLSRJF_ID_BITS + 2 * TIME_BITS + MLSRJF_LVL_BITS,
  localparam int IN_W     = ((IN_FW + 7) / 8) * 8,
  localparam int OUT_FW   = 3 * TIME_BITS + MLSRJF_ID_BITS + MLSRJF_LVL_BITS + 3
                            + 2 * MLSRJF_SUM_BITS,
  localparam int OUT_W    = ((OUT_FW + 7) / 8) * 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // Input channel
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  // tdata: task_id, arrival, burst, level
  input  wire logic [IN_W-1:0]   in_tdata,
  // tuser: kind
  input  wire logic              in_tuser,
  // Result channel
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  // tdata: now, run_id, run_level, first_run, response, finished, turnaround,
  //        response_sum, turnaround_sum, all_done
  output logic [OUT_W-1:0]       out_tdata,
  // tuser: idle
  output logic                   out_tuser
);

  localparam int AW = $clog2(MAX_TASKS);
  localparam int CW = $clog2(MAX_TASKS + 1);
  localparam int TW = TIME_BITS;
  localparam int SW = MLSRJF_SUM_BITS;
  localparam int IW = MLSRJF_ID_BITS;
  localparam int LW = MLSRJF_LVL_BITS;
  // Table entry: id, arrival, burst, remaining, level (lowest first)
  localparam int EW = IW + 3 * TW + LW;
  localparam int E_ARR = IW;
  localparam int E_BUR = IW + TW;
  localparam int E_REM = IW + 2 * TW;
  localparam int E_LVL = IW + 3 * TW;

  // Input fields
  logic [IW-1:0] in_id;
  logic [TW-1:0] in_arrival;
  logic [TW-1:0] in_burst;
  logic [LW-1:0] in_level;

  assign in_id      = in_tdata[IW-1:0];
  assign in_arrival = in_tdata[IW +: TW];
  assign in_burst   = in_tdata[IW + TW +: TW];
  assign in_level   = in_tdata[IW + 2 * TW +: LW];

  // State
  sched_state_t   state_r, state_nxt;
  logic [CW-1:0]  entry_count_r, entry_count_nxt;
  logic [CW-1:0]  done_count_r, done_count_nxt;
  logic [TW-1:0]  tick_now_r, tick_now_nxt;
  logic [SW-1:0]  resp_sum_r, resp_sum_nxt;
  logic [SW-1:0]  turn_sum_r, turn_sum_nxt;
  logic [AW-1:0]  scan_idx_r, scan_idx_nxt;
  logic [AW-1:0]  cmp_idx_r, cmp_idx_nxt;
  logic           cmp_valid_r, cmp_valid_nxt;
  logic           found_r, found_nxt;
  logic [AW-1:0]  best_idx_r, best_idx_nxt;
  logic [1:0]     best_rank_r, best_rank_nxt;
  logic [TW-1:0]  best_rem_r, best_rem_nxt;
  logic [IW-1:0]  best_id_r, best_id_nxt;
  logic [TW-1:0]  best_arr_r, best_arr_nxt;
  logic [TW-1:0]  best_bur_r, best_bur_nxt;
  logic [LW-1:0]  best_lvl_r, best_lvl_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0] out_data_r, out_data_nxt;
  logic           out_idle_r, out_idle_nxt;

  // Control
  logic           in_xfer;
  logic           add_xfer;
  logic           tick_xfer;
  logic           last_issue;
  logic           emit;
  logic [CW-1:0]  cnt_m1;

  // RAM port
  logic           ram_we;
  logic [AW-1:0]  ram_waddr;
  logic [EW-1:0]  ram_wdata;
  logic [EW-1:0]  ram_rdata;

  // Compare unit
  logic [IW-1:0]  c_id;
  logic [TW-1:0]  c_arr;
  logic [TW-1:0]  c_bur;
  logic [TW-1:0]  c_rem;
  logic [LW-1:0]  c_lvl;
  logic [1:0]     c_rank;
  logic           c_ready;
  logic           c_better;

  // Finish arithmetic
  logic [TW-1:0]  f_elapsed;
  logic [TW-1:0]  f_rem_dec;
  logic           f_first;
  logic           f_fin;
  logic [TW-1:0]  f_resp;
  logic [TW-1:0]  f_turn;
  logic [LW-1:0]  f_rlev;
  logic [IW-1:0]  f_rid;
  logic           f_all_done;
  logic [OUT_FW-1:0] f_fields;

  assign in_xfer    = in_tvalid && in_tready;
  assign add_xfer   = in_xfer && (in_tuser == KIND_ADD);
  assign tick_xfer  = in_xfer && (in_tuser == KIND_TICK);
  assign cnt_m1     = entry_count_r - 1'b1;
  assign last_issue = (scan_idx_r == cnt_m1[AW-1:0]);

  // Task table
  mlsrjf_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_TASKS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (scan_idx_r),
    .rdata (ram_rdata)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (tick_xfer) begin
          state_nxt = (entry_count_r == '0) ? ST_FINISH : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (last_issue) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (emit) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control outputs
  always_comb begin
    in_tready     = 1'b0;
    emit          = 1'b0;
    cmp_valid_nxt = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
      end
      ST_SCAN: begin
        cmp_valid_nxt = 1'b1;
      end
      ST_DRAIN: begin
      end
      ST_FINISH: begin
        emit = !out_valid_r || out_tready;
      end
      default: begin
      end
    endcase
  end

  // Compare unit: one table entry per cycle
  always_comb begin
    c_id     = ram_rdata[IW-1:0];
    c_arr    = ram_rdata[E_ARR +: TW];
    c_bur    = ram_rdata[E_BUR +: TW];
    c_rem    = ram_rdata[E_REM +: TW];
    c_lvl    = ram_rdata[E_LVL +: LW];
    c_rank   = level_rank(c_lvl);
    c_ready  = (c_arr <= tick_now_r) && (c_rem != '0);
    c_better = cmp_valid_r && c_ready &&
               (!found_r || (c_rank < best_rank_r) ||
                ((c_rank == best_rank_r) && (c_rem < best_rem_r)));
  end

  // Advance scan and hold the best candidate
  always_comb begin
    scan_idx_nxt  = scan_idx_r;
    cmp_idx_nxt   = scan_idx_r;
    found_nxt     = found_r;
    best_idx_nxt  = best_idx_r;
    best_rank_nxt = best_rank_r;
    best_rem_nxt  = best_rem_r;
    best_id_nxt   = best_id_r;
    best_arr_nxt  = best_arr_r;
    best_bur_nxt  = best_bur_r;
    best_lvl_nxt  = best_lvl_r;
    if (tick_xfer) begin
      scan_idx_nxt = '0;
      found_nxt    = 1'b0;
    end else begin
      if (state_r == ST_SCAN) begin
        scan_idx_nxt = scan_idx_r + 1'b1;
      end
      if (c_better) begin
        found_nxt     = 1'b1;
        best_idx_nxt  = cmp_idx_r;
        best_rank_nxt = c_rank;
        best_rem_nxt  = c_rem;
        best_id_nxt   = c_id;
        best_arr_nxt  = c_arr;
        best_bur_nxt  = c_bur;
        best_lvl_nxt  = c_lvl;
      end
    end
  end

  // Run the chosen task and form the result
  always_comb begin
    f_elapsed  = tick_now_r - best_arr_r;
    f_rem_dec  = best_rem_r - 1'b1;
    f_first    = found_r && (best_bur_r == best_rem_r);
    f_fin      = found_r && (f_rem_dec == '0);
    f_resp     = f_first ? f_elapsed : '0;
    f_turn     = f_fin ? (f_elapsed + 1'b1) : '0;
    f_rid      = found_r ? best_id_r : '0;
    f_rlev     = found_r ? best_rank_r : '0;

    entry_count_nxt = entry_count_r;
    done_count_nxt  = done_count_r;
    tick_now_nxt    = tick_now_r;
    resp_sum_nxt    = resp_sum_r;
    turn_sum_nxt    = turn_sum_r;

    if (add_xfer && (entry_count_r < CW'(MAX_TASKS))) begin
      entry_count_nxt = entry_count_r + 1'b1;
    end
    if (emit) begin
      tick_now_nxt = tick_now_r + 1'b1;
      resp_sum_nxt = resp_sum_r + SW'(f_resp);
      turn_sum_nxt = turn_sum_r + SW'(f_turn);
      if (f_fin) begin
        done_count_nxt = done_count_r + 1'b1;
      end
    end

    f_all_done = (done_count_nxt == entry_count_r);
    f_fields   = {f_all_done, turn_sum_nxt, resp_sum_nxt, f_turn, f_fin, f_resp,
                  f_first, f_rlev, f_rid, tick_now_r};
  end

  // Table writes: append on add, write back remaining time on a run
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = entry_count_r[AW-1:0];
    ram_wdata = {in_level, in_burst, in_burst, in_arrival, in_id};
    if (add_xfer && (entry_count_r < CW'(MAX_TASKS))) begin
      ram_we = 1'b1;
    end else if (emit && found_r) begin
      ram_we    = 1'b1;
      ram_waddr = best_idx_r;
      ram_wdata = {best_lvl_r, f_rem_dec, best_bur_r, best_arr_r, best_id_r};
    end
  end

  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_idle_nxt  = out_idle_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = OUT_W'(f_fields);
      out_idle_nxt  = !found_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_idle_r;

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      entry_count_r <= '0;
      done_count_r  <= '0;
      tick_now_r    <= '0;
      resp_sum_r    <= '0;
      turn_sum_r    <= '0;
      cmp_valid_r   <= 1'b0;
      found_r       <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      entry_count_r <= entry_count_nxt;
      done_count_r  <= done_count_nxt;
      tick_now_r    <= tick_now_nxt;
      resp_sum_r    <= resp_sum_nxt;
      turn_sum_r    <= turn_sum_nxt;
      cmp_valid_r   <= cmp_valid_nxt;
      found_r       <= found_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    scan_idx_r  <= scan_idx_nxt;
    cmp_idx_r   <= cmp_idx_nxt;
    best_idx_r  <= best_idx_nxt;
    best_rank_r <= best_rank_nxt;
    best_rem_r  <= best_rem_nxt;
    best_id_r   <= best_id_nxt;
    best_arr_r  <= best_arr_nxt;
    best_bur_r  <= best_bur_nxt;
    best_lvl_r  <= best_lvl_nxt;
    out_data_r  <= out_data_nxt;
    out_idle_r  <= out_idle_nxt;
  end

`ifndef SYNTH
  a_done_le_count: assert property (@(posedge clk) disable iff (!rst_n)
    done_count_r <= entry_count_r)
    else $error("completed task count exceeds loaded task count");

  a_tick_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tuser == KIND_TICK)) |=> !in_tready)
    else $error("input taken again right after a tick transfer");

  a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> ($past(state_r) == ST_FINISH))
    else $error("result raised outside the finish step");

  a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_SCAN) || (state_r == ST_DRAIN)) |-> !ram_we)
    else $error("task table written during a scan");
`endif

endmodule

`default_nettype wire

>>> test/multilevel_srjf_scheduler_top_test.sv
// ----------------------------------------------------------------------------
// multilevel_srjf_scheduler_top_test
// Self-checking bench for the multilevel SRJF scheduler. A queue of task loads
// and scheduling ticks feeds a stream driver. A scheduler model runs beside the
// block and predicts every tick result, and a monitor checks each result
// field by field. Both stream sides idle in phases, and the result side once
// holds off long enough to back the input up.
// ----------------------------------------------------------------------------
module multilevel_srjf_scheduler_top_test;
  import mlsrjf_pkg::*;

  localparam int TW          = MLSRJF_TIME_BITS;
  localparam int NTASK       = MLSRJF_MAX_TASKS;
  localparam int IN_FW       = MLSRJF_ID_BITS + 2 * TW + MLSRJF_LVL_BITS;
  localparam int IN_W        = ((IN_FW + 7) / 8) * 8;
  localparam int OUT_FW      = 3 * TW + MLSRJF_ID_BITS + MLSRJF_LVL_BITS + 3
                               + 2 * MLSRJF_SUM_BITS;
  localparam int OUT_W       = ((OUT_FW + 7) / 8) * 8;
  localparam int QUIET_LIMIT = 5000;
  localparam int HOLD_CYCLES = 600;
  localparam int DRAIN_WAIT  = NTASK + 8;

  typedef struct packed {
    logic                      kind;
    logic [MLSRJF_ID_BITS-1:0] task_id;
    logic [TW-1:0]             arrival;
    logic [TW-1:0]             burst;
    logic [1:0]                level;
  } sched_item_t;

  typedef struct packed {
    logic [TW-1:0]              now;
    logic                       idle;
    logic [MLSRJF_ID_BITS-1:0]  run_id;
    logic [1:0]                 run_level;
    logic                       first_run;
    logic [TW-1:0]              response;
    logic                       finished;
    logic [TW-1:0]              turnaround;
    logic [MLSRJF_SUM_BITS-1:0] response_sum;
    logic [MLSRJF_SUM_BITS-1:0] turnaround_sum;
    logic                       all_done;
  } dispatch_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata = '0;
  logic             in_tuser = 1'b0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  logic             out_tuser;

  multilevel_srjf_scheduler_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Scheduler model state
  logic [MLSRJF_ID_BITS-1:0]  tbl_id      [NTASK];
  logic [TW-1:0]              tbl_arrival [NTASK];
  logic [TW-1:0]              tbl_burst   [NTASK];
  logic [TW-1:0]              tbl_left    [NTASK];
  logic [1:0]                 tbl_level   [NTASK];
  int                         tbl_count = 0;
  int                         done_tasks = 0;
  logic [TW-1:0]              sched_now = '0;
  logic [MLSRJF_SUM_BITS-1:0] resp_acc = '0;
  logic [MLSRJF_SUM_BITS-1:0] turn_acc = '0;

  sched_item_t stim_items [$];
  dispatch_t   expected_dispatches [$];
  sched_item_t cur_item;
  int          stim_total = 0;
  int          items_taken = 0;
  int          error_count = 0;
  int          quiet_cycles = 0;
  int          hold_left = 0;
  bit          hold_done = 1'b0;

  // Planning state used while the stimulus queue is built
  logic [TW-1:0] plan_now = '0;
  int            plan_count = 0;

  // Store a task unless the table is full
  function automatic void load_task(input sched_item_t it);
    if (tbl_count < NTASK) begin
      tbl_id[tbl_count]      = it.task_id;
      tbl_arrival[tbl_count] = it.arrival;
      tbl_burst[tbl_count]   = it.burst;
      tbl_left[tbl_count]    = it.burst;
      tbl_level[tbl_count]   = it.level;
      tbl_count++;
    end
  endfunction

  // Pick the ready task of the best level with least time left, run it a tick
  function automatic dispatch_t run_tick();
    dispatch_t  r;
    int         pick;
    logic [1:0] pick_rank;
    logic [1:0] rank;
    logic [TW-1:0] pick_left;
    r = '0;
    pick = -1;
    pick_rank = RANK_LOW;
    pick_left = '0;
    for (int i = 0; i < tbl_count; i++) begin
      if (tbl_arrival[i] <= sched_now && tbl_left[i] != '0) begin
        if (tbl_level[i] == LEVEL_HIGH) rank = RANK_HIGH;
        else if (tbl_level[i] == LEVEL_MEDIUM) rank = RANK_MEDIUM;
        else rank = RANK_LOW;
        if (pick < 0 || rank < pick_rank || (rank == pick_rank && tbl_left[i] < pick_left)) begin
          pick = i;
          pick_rank = rank;
          pick_left = tbl_left[i];
        end
      end
    end
    r.now = sched_now;
    r.idle = (pick < 0);
    if (pick >= 0) begin
      r.run_id = tbl_id[pick];
      r.run_level = pick_rank;
      if (tbl_burst[pick] == tbl_left[pick]) begin
        r.first_run = 1'b1;
        r.response = sched_now - tbl_arrival[pick];
        resp_acc = resp_acc + MLSRJF_SUM_BITS'(r.response);
      end
      tbl_left[pick] = tbl_left[pick] - 1'b1;
      if (tbl_left[pick] == '0) begin
        r.finished = 1'b1;
        r.turnaround = sched_now - tbl_arrival[pick] + 1'b1;
        turn_acc = turn_acc + MLSRJF_SUM_BITS'(r.turnaround);
        done_tasks++;
      end
    end
    r.response_sum = resp_acc;
    r.turnaround_sum = turn_acc;
    r.all_done = (done_tasks == tbl_count);
    sched_now = sched_now + 1'b1;
    return r;
  endfunction

  // Idle or stall percentage for the current phase
  function automatic int idle_pct(input bit sender_side);
    int phase;
    phase = (items_taken / 60) % 4;
    if (phase == 3) return 30;
    if (phase == 1 && sender_side) return 54;
    if (phase == 2 && !sender_side) return 54;
    return 0;
  endfunction

  task automatic queue_add(input logic [MLSRJF_ID_BITS-1:0] id, input logic [TW-1:0] arr,
                           input logic [TW-1:0] burst, input logic [1:0] lvl);
    sched_item_t it;
    it.kind = KIND_ADD;
    it.task_id = id;
    it.arrival = arr;
    it.burst = burst;
    it.level = lvl;
    stim_items.push_back(it);
    plan_count++;
  endtask

  task automatic queue_ticks(input int n);
    sched_item_t it;
    it = '0;
    it.kind = KIND_TICK;
    it.task_id = MLSRJF_ID_BITS'($urandom_range(255));
    it.arrival = TW'($urandom_range(65535));
    it.burst = TW'($urandom_range(65535));
    it.level = 2'($urandom_range(3));
    repeat (n) begin
      stim_items.push_back(it);
      plan_now = plan_now + 1'b1;
    end
  endtask

  // Load a task that arrives soon with a short burst
  task automatic queue_near_task();
    queue_add(MLSRJF_ID_BITS'($urandom_range(255)), TW'(plan_now + $urandom_range(0, 24)),
              TW'(($urandom_range(4) == 0) ? 1 : $urandom_range(1, 40)),
              2'($urandom_range(3)));
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got_v,
                                 input logic [31:0] want_v);
    error_count++;
    $display("mismatch in %s: got %0h, expected %0h", what, got_v, want_v);
  endtask

  // Build the stimulus, release reset, wait for the drain and judge
  initial begin
    // Tick on an empty table
    queue_ticks(1);
    // Every level code, extreme ids, tie between two low tasks
    queue_add(8'h00, 16'd0, 16'd2, 2'd1);
    queue_add(8'hFF, 16'd0, 16'd1, 2'd2);
    queue_add(8'h5A, 16'd3, 16'd1, 2'd0);
    queue_add(8'hA5, 16'd0, 16'd1, 2'd3);
    // Run all of them and tick once past completion
    queue_ticks(6);
    // Not yet arrived, shorter remaining wins, a later high task preempts
    queue_add(8'h3C, 16'd8, 16'd3, 2'd1);
    queue_add(8'hC3, 16'd8, 16'd2, 2'd1);
    queue_add(8'h81, 16'd11, 16'd1, 2'd1);
    queue_ticks(7);

    // Random part: mostly ticks with tasks trickling in
    for (int r = 0; r < 880; r++) begin
      if (r == 700) begin
        // Fill the table, park a task that never arrives and a zero burst,
        // then offer loads that a full table drops
        while (plan_count < NTASK - 2) queue_near_task();
        queue_add(MLSRJF_ID_BITS'($urandom_range(255)), 16'hFFFF, 16'hFFFF,
                  2'($urandom_range(3)));
        queue_add(MLSRJF_ID_BITS'($urandom_range(255)), plan_now, 16'd0,
                  2'($urandom_range(3)));
        repeat (4) queue_near_task();
      end else if (plan_count < NTASK - 2 && $urandom_range(35) == 0) begin
        repeat ($urandom_range(1, 3)) begin
          if (plan_count < NTASK - 2) queue_near_task();
        end
      end else begin
        queue_ticks(1);
      end
    end
    stim_total = stim_items.size();

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    wait (items_taken == stim_total);
    wait (expected_dispatches.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (error_count == 0 && expected_dispatches.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Drive items from the queue; predict each one as its transfer completes
  always @(posedge clk) begin : item_driver
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        if (cur_item.kind == KIND_TICK) expected_dispatches.push_back(run_tick());
        else load_task(cur_item);
        items_taken <= items_taken + 1;
      end
      if (!in_tvalid || in_tready) begin
        if (stim_items.size() != 0 && $urandom_range(99) >= idle_pct(1'b1)) begin
          cur_item = stim_items.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= {{(IN_W-IN_FW){1'b0}}, cur_item.level, cur_item.burst,
                       cur_item.arrival, cur_item.task_id};
          in_tuser <= cur_item.kind;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Stall the result side at random; hold off once for a long stretch
  always @(posedge clk) begin : result_ready
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (!hold_done && items_taken >= 500) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= idle_pct(1'b0));
    end
  end

  // Check each result transfer against the oldest prediction
  always @(posedge clk) begin : result_monitor
    dispatch_t got;
    dispatch_t want;
    logic [OUT_W-OUT_FW-1:0] pad_bits;
    if (rst_n && out_tvalid && out_tready) begin
      {pad_bits, got.all_done, got.turnaround_sum, got.response_sum, got.turnaround,
       got.finished, got.response, got.first_run, got.run_level, got.run_id,
       got.now} = out_tdata;
      got.idle = out_tuser;
      if (expected_dispatches.size() == 0) begin
        report_mismatch("unexpected result, now", 32'(got.now), '0);
      end else begin
        want = expected_dispatches.pop_front();
        if (got.now !== want.now) report_mismatch("now", 32'(got.now), 32'(want.now));
        if (got.idle !== want.idle) report_mismatch("idle", 32'(got.idle), 32'(want.idle));
        if (got.run_id !== want.run_id)
          report_mismatch("run_id", 32'(got.run_id), 32'(want.run_id));
        if (got.run_level !== want.run_level)
          report_mismatch("run_level", 32'(got.run_level), 32'(want.run_level));
        if (got.first_run !== want.first_run)
          report_mismatch("first_run", 32'(got.first_run), 32'(want.first_run));
        if (got.response !== want.response)
          report_mismatch("response", 32'(got.response), 32'(want.response));
        if (got.finished !== want.finished)
          report_mismatch("finished", 32'(got.finished), 32'(want.finished));
        if (got.turnaround !== want.turnaround)
          report_mismatch("turnaround", 32'(got.turnaround), 32'(want.turnaround));
        if (got.response_sum !== want.response_sum)
          report_mismatch("response_sum", got.response_sum, want.response_sum);
        if (got.turnaround_sum !== want.turnaround_sum)
          report_mismatch("turnaround_sum", got.turnaround_sum, want.turnaround_sum);
        if (got.all_done !== want.all_done)
          report_mismatch("all_done", 32'(got.all_done), 32'(want.all_done));
      end
    end
  end

  // End the run when no transfer happens for too long
  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

>>> files.f
design/mlsrjf_pkg.sv
design/mlsrjf_ram.sv
design/multilevel_srjf_scheduler_top.sv
test/multilevel_srjf_scheduler_top_test.sv
